// ===== hw/rtl/cmdf_pkg.sv =====
package cmdf_pkg;

	localparam logic [7:0]  FLAG_BYTE   = 8'hF9;
	localparam logic [7:0]  CRC_POLY    = 8'hE0;
	localparam logic [7:0]  CRC_INIT    = 8'hFF;
	localparam logic [7:0]  PF_MASK     = 8'h10;
	localparam int          PF_POS      = 4;
	localparam int          EA_POS      = 0;
	localparam logic [14:0] MAX_PAYLOAD_RST = 15'd256;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_ADDR,
		PH_CTRL,
		PH_LEN1,
		PH_LEN2,
		PH_DATA,
		PH_FCS,
		PH_END
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_ACCEPT,
		KIND_DROP
	} kind_t;

	typedef struct packed {
		logic        truncated;
		logic        fcs_ok;
		logic [14:0] payload_len;
		logic [7:0]  frame_kind;
		logic        poll_final;
		logic        cmd_resp;
		logic [5:0]  channel;
		logic [7:0]  out_byte;
		kind_t       out_kind;
	} res_t;

	// reflected CRC-8, one byte
	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/cmux_basic_frame_deframer.sv =====
// channel  dir  transfer when              payload
// s_*      in   s_tvalid & s_tready        tdata[7:0] rx_byte
// m_*      out  m_tvalid & m_tready        tdata result fields, tuser out_kind
// apb      in   psel & penable & pwrite    addr 0: max_payload[14:0]
//
// One received byte per cycle; the header parser and CRC step are
// combinational, so s_tready stays high unless the result queue is full.
// Results are registered in the result queue before they appear on m_*.
// Reset clears the parser and the queue; max_payload returns to 256.
// A stalled m_tready backs up FIFO_DEPTH results before s_tready drops.
module cmux_basic_frame_deframer
	import cmdf_pkg::*;
#(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] out_byte, [13:8] channel, [14] cmd_resp, [15] poll_final,
	// [23:16] frame_kind, [38:24] payload_len, [39] fcs_ok, [40] truncated
	output logic [47:0] m_tdata,
	output logic [1:0]  m_tuser,   // [1:0] out_kind
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [14:0] max_payload_q;
	logic        push, full;
	res_t        res, qres;
	logic        sel_max;

	assign pready  = 1'b1;
	assign sel_max = (paddr[2] == 1'b0);
	assign prdata  = sel_max ? {17'd0, max_payload_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (psel && penable && pwrite && pready && sel_max) begin
			max_payload_q <= pwdata[14:0];
		end
	end

	cmdf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_byte     (s_tdata),
		.queue_full  (full),
		.max_payload (max_payload_q),
		.in_ready    (s_tready),
		.push        (push),
		.res         (res)
	);

	cmdf_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (FIFO_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (res),
		.full   (full),
		.rvalid (m_tvalid),
		.pop    (m_tready),
		.rdata  (qres)
	);

	assign m_tuser = qres.out_kind;
	assign m_tdata = {7'd0, qres.truncated, qres.fcs_ok, qres.payload_len,
		qres.frame_kind, qres.poll_final, qres.cmd_resp, qres.channel, qres.out_byte};

endmodule

// ===== hw/rtl/cmdf_front.sv =====
module cmdf_front
	import cmdf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [7:0]  in_byte,
	input  logic        queue_full,
	input  logic [14:0] max_payload,
	output logic        in_ready,
	output logic        push,
	output res_t        res
);

	phase_t      phase_q, phase_d;
	logic [7:0]  crc_q, crc_d;
	logic [14:0] count_q, count_d;
	logic [14:0] len_q, len_d;
	logic [5:0]  chan_q, chan_d;
	logic        cr_q, cr_d;
	logic        pf_q, pf_d;
	logic [7:0]  type_q, type_d;
	logic        good_q, good_d;
	logic        ovr_q, ovr_d;
	logic        has_res;
	logic [7:0]  crc_nx;
	logic [14:0] count_inc;
	logic [14:0] len1;
	logic [14:0] len2;

	assign in_ready  = !queue_full;
	assign crc_nx    = crc_step(crc_q, in_byte);
	assign count_inc = count_q + 15'd1;
	assign len1      = {8'd0, in_byte[7:1]};
	assign len2      = {in_byte, len_q[6:0]};

	always_comb begin
		phase_d = phase_q;
		crc_d   = crc_q;
		count_d = count_q;
		len_d   = len_q;
		chan_d  = chan_q;
		cr_d    = cr_q;
		pf_d    = pf_q;
		type_d  = type_q;
		good_d  = good_q;
		ovr_d   = ovr_q;
		has_res = 1'b0;
		res.out_kind    = KIND_BYTE;
		res.out_byte    = 8'd0;
		res.channel     = chan_q;
		res.cmd_resp    = cr_q;
		res.poll_final  = pf_q;
		res.frame_kind  = type_q;
		res.payload_len = len_q;
		res.fcs_ok      = 1'b0;
		res.truncated   = 1'b0;
		unique case (phase_q)
			PH_HUNT: begin
				if (in_byte == FLAG_BYTE) begin
					crc_d   = CRC_INIT;
					count_d = '0;
					len_d   = '0;
					good_d  = 1'b0;
					ovr_d   = 1'b0;
					phase_d = PH_ADDR;
				end
			end
			PH_ADDR: begin
				crc_d   = crc_nx;
				cr_d    = in_byte[1];
				chan_d  = in_byte[7:2];
				phase_d = PH_CTRL;
			end
			PH_CTRL: begin
				crc_d   = crc_nx;
				pf_d    = in_byte[PF_POS];
				type_d  = in_byte & ~PF_MASK;
				phase_d = PH_LEN1;
			end
			PH_LEN1: begin
				crc_d = crc_nx;
				len_d = len1;
				if (!in_byte[EA_POS]) begin
					phase_d = PH_LEN2;
				end else begin
					phase_d = (len1 == '0) ? PH_FCS : PH_DATA;
				end
			end
			PH_LEN2: begin
				crc_d   = crc_nx;
				len_d   = len2;
				phase_d = (len2 == '0) ? PH_FCS : PH_DATA;
			end
			PH_DATA: begin
				count_d = count_inc;
				// reaching the length takes precedence over the limit
				if (count_inc == len_q) begin
					phase_d = PH_FCS;
				end else if (max_payload != '0 && count_inc == max_payload) begin
					ovr_d   = 1'b1;
					phase_d = PH_END;
				end
				has_res      = 1'b1;
				res.out_byte = in_byte;
			end
			PH_FCS: begin
				good_d  = (in_byte == (CRC_INIT ^ crc_q));
				phase_d = PH_END;
			end
			PH_END: begin
				phase_d       = PH_HUNT;
				has_res       = 1'b1;
				res.out_kind  = (in_byte == FLAG_BYTE) ? KIND_ACCEPT : KIND_DROP;
				res.fcs_ok    = good_q;
				res.truncated = ovr_q;
			end
		endcase
	end

	logic fire;
	assign fire = in_valid && in_ready;
	assign push = fire && has_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			crc_q   <= CRC_INIT;
			count_q <= '0;
			len_q   <= '0;
			chan_q  <= '0;
			cr_q    <= 1'b0;
			pf_q    <= 1'b0;
			type_q  <= '0;
			good_q  <= 1'b0;
			ovr_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			crc_q   <= crc_d;
			count_q <= count_d;
			len_q   <= len_d;
			chan_q  <= chan_d;
			cr_q    <= cr_d;
			pf_q    <= pf_d;
			type_q  <= type_d;
			good_q  <= good_d;
			ovr_q   <= ovr_d;
		end
	end

endmodule

// ===== hw/rtl/cmdf_fifo.sv =====
module cmdf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	output logic             rvalid,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign rvalid  = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && rvalid;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + AW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/cmdf_checker.sv =====
module cmdf_checker
	import cmdf_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);

	// held result must not change while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == KIND_BYTE || m_tuser == KIND_ACCEPT ||
			m_tuser == KIND_DROP))
		else $error("bad result kind");

	// payload bytes never carry frame status
	a_byte_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_BYTE |-> m_tdata[40:39] == 2'b00)
		else $error("status flags on payload byte");

	a_end_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_BYTE |-> m_tdata[7:0] == 8'd0)
		else $error("data byte on frame result");

	a_cfg_read: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[2] == 1'b0 |=>
			prdata[14:0] == $past(pwdata[14:0]) || paddr[2] != 1'b0)
		else $error("register readback mismatch");

endmodule

bind cmux_basic_frame_deframer cmdf_checker u_cmdf_checker (.*);

// ===== verif/cmux_deframer_checker.sv =====
module cmux_deframer_checker
	import cmdf_pkg::*;
#(
	parameter logic [2:0] MAXP_ADDR = 3'd0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          outstanding
);

	phase_t      rx_phase;
	logic [7:0]  hdr_crc;
	logic [14:0] data_count;
	logic [14:0] frame_len;
	logic [14:0] max_len;
	logic [5:0]  hdr_chan;
	logic        hdr_cr;
	logic        hdr_pf;
	logic [7:0]  hdr_type;
	logic        fcs_match;
	logic        cut_short;
	res_t        pending_results[$];
	int          errs = 0;

	// reflected CRC-8, bit-serial, LSB first
	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic res_t frame_result(input kind_t k, input logic [7:0] data,
			input logic at_end);
		res_t r;
		r.out_kind    = k;
		r.out_byte    = data;
		r.channel     = hdr_chan;
		r.cmd_resp    = hdr_cr;
		r.poll_final  = hdr_pf;
		r.frame_kind  = hdr_type;
		r.payload_len = frame_len;
		r.fcs_ok      = at_end & fcs_match;
		r.truncated   = at_end & cut_short;
		return r;
	endfunction

	task automatic absorb_byte(input logic [7:0] b);
		case (rx_phase)
			PH_HUNT: begin
				if (b == FLAG_BYTE) begin
					hdr_crc    = CRC_INIT;
					data_count = '0;
					frame_len  = '0;
					fcs_match  = 1'b0;
					cut_short  = 1'b0;
					rx_phase   = PH_ADDR;
				end
			end
			PH_ADDR: begin
				hdr_crc  = crc8_next(hdr_crc, b);
				hdr_cr   = b[1];
				hdr_chan = b[7:2];
				rx_phase = PH_CTRL;
			end
			PH_CTRL: begin
				hdr_crc  = crc8_next(hdr_crc, b);
				hdr_pf   = b[PF_POS];
				hdr_type = b & ~PF_MASK;
				rx_phase = PH_LEN1;
			end
			PH_LEN1: begin
				hdr_crc   = crc8_next(hdr_crc, b);
				frame_len = {8'd0, b[7:1]};
				if (!b[EA_POS]) begin
					rx_phase = PH_LEN2;
				end else begin
					rx_phase = (frame_len == '0) ? PH_FCS : PH_DATA;
				end
			end
			PH_LEN2: begin
				hdr_crc   = crc8_next(hdr_crc, b);
				frame_len = frame_len | {b, 7'd0};
				rx_phase  = (frame_len == '0) ? PH_FCS : PH_DATA;
			end
			PH_DATA: begin
				data_count = data_count + 15'd1;
				// length wins over the limit when both are hit at once
				if (data_count == frame_len) begin
					rx_phase = PH_FCS;
				end else if (max_len != '0 && data_count == max_len) begin
					cut_short = 1'b1;
					rx_phase  = PH_END;
				end
				pending_results.push_back(frame_result(KIND_BYTE, b, 1'b0));
			end
			PH_FCS: begin
				fcs_match = (b == (8'hFF ^ hdr_crc));
				rx_phase  = PH_END;
			end
			default: begin
				rx_phase = PH_HUNT;
				pending_results.push_back(frame_result(
					(b == FLAG_BYTE) ? KIND_ACCEPT : KIND_DROP, 8'd0, 1'b1));
			end
		endcase
	endtask

	function automatic void cmp(input string name, input logic [31:0] want,
			input logic [31:0] seen);
		if (want !== seen) begin
			$error("%s: expected %0h, got %0h", name, want, seen);
			errs++;
		end
	endfunction

	task automatic check_result();
		res_t want;
		if (pending_results.size() == 0) begin
			$error("unexpected result transfer: out_kind %0d, tdata %0h", m_tuser, m_tdata);
			errs++;
		end else begin
			want = pending_results.pop_front();
			cmp("out_kind", want.out_kind, m_tuser);
			cmp("out_byte", want.out_byte, m_tdata[7:0]);
			cmp("channel", want.channel, m_tdata[13:8]);
			cmp("cmd_resp", want.cmd_resp, m_tdata[14]);
			cmp("poll_final", want.poll_final, m_tdata[15]);
			cmp("frame_kind", want.frame_kind, m_tdata[23:16]);
			cmp("payload_len", want.payload_len, m_tdata[38:24]);
			cmp("fcs_ok", want.fcs_ok, m_tdata[39]);
			cmp("truncated", want.truncated, m_tdata[40]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_phase   = PH_HUNT;
			hdr_crc    = CRC_INIT;
			data_count = '0;
			frame_len  = '0;
			max_len    = MAX_PAYLOAD_RST;
			hdr_chan   = '0;
			hdr_cr     = 1'b0;
			hdr_pf     = 1'b0;
			hdr_type   = '0;
			fcs_match  = 1'b0;
			cut_short  = 1'b0;
			pending_results.delete();
			fail_count  <= errs;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_result();
			end
			if (s_tvalid && s_tready) begin
				absorb_byte(s_tdata);
			end
			// register takes effect after this edge, so bytes above used the old value
			if (psel && penable && pwrite && pready && paddr == MAXP_ADDR) begin
				max_len = pwdata[14:0];
			end
			fail_count  <= errs;
			outstanding <= pending_results.size();
		end
	end

endmodule

// ===== verif/tb_cmux_basic_frame_deframer.sv =====
module tb_cmux_basic_frame_deframer;
	import cmdf_pkg::*;

	localparam logic [2:0] MAXP_ADDR = 3'd0;
	localparam int SETTLE = 4;
	localparam int ITEMS = 1450;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int outstanding;
	int send_idle = 0;
	int stall_pct = 0;
	int bytes_sent = 0;
	int cur_max = MAX_PAYLOAD_RST;
	int seg_end;
	bit paused = 1'b0;

	always #5 clk = ~clk;

	cmux_basic_frame_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	cmux_deframer_checker #(
		.MAXP_ADDR (MAXP_ADDR)
	) chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// check byte generation for well-formed frames
	function automatic logic [7:0] fcs_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		repeat (8) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_max_payload(input logic [14:0] v);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= MAXP_ADDR;
		pwdata  <= {17'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cur_max = v;
	endtask

	// cut > 0 keeps only the first cut bytes of the frame
	task automatic send_frame(input logic [7:0] addr, input logic [7:0] ctrl, input int len,
			input bit two_len, input bit fcs_good, input bit end_good, input int cut);
		logic [7:0] fb[$];
		logic [7:0] crc;
		logic [7:0] l1;
		logic [7:0] v;
		int         n;
		bit         over;
		l1 = {len[6:0], ~two_len};
		crc = fcs_update(fcs_update(fcs_update(CRC_INIT, addr), ctrl), l1);
		fb = '{FLAG_BYTE, addr, ctrl, l1};
		if (two_len) begin
			fb.push_back(len[14:7]);
			crc = fcs_update(crc, len[14:7]);
		end
		over = (cur_max != 0) && (len > cur_max);
		n = over ? cur_max : len;
		repeat (n) begin
			v = ($urandom_range(15) == 0) ? FLAG_BYTE : 8'($urandom);
			fb.push_back(v);
		end
		if (!over) begin
			fb.push_back(fcs_good ? (8'hFF ^ crc) : 8'($urandom));
		end
		v = 8'($urandom);
		if (end_good || v == FLAG_BYTE) begin
			v = end_good ? FLAG_BYTE : 8'h00;
		end
		fb.push_back(v);
		if (cut > 0) begin
			while (fb.size() > cut) begin
				void'(fb.pop_back());
			end
		end
		foreach (fb[i]) begin
			push_byte(fb[i]);
		end
	endtask

	task automatic random_frame();
		int len;
		int r;
		int cut;
		bit two;
		two = ($urandom_range(3) == 0);
		r = $urandom_range(99);
		if (r < 10) begin
			len = 0;
		end else if (r < 75) begin
			len = $urandom_range(1, 16);
		end else if (r < 97 || !two) begin
			len = $urandom_range(17, 127);
		end else begin
			len = $urandom_range(128, 400);
		end
		// full 15-bit lengths only where a small limit cuts them off
		if (two && cur_max <= 64 && $urandom_range(7) == 0) begin
			len = $urandom_range(0, 32767);
		end
		cut = ($urandom_range(19) == 0) ? $urandom_range(1, 8) : -1;
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 247)));
		end
		send_frame(8'($urandom), 8'($urandom), len, two, $urandom_range(3) != 0,
			$urandom_range(9) != 0, cut);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// noise while hunting
		push_byte(8'h00);
		push_byte(8'hFF);
		// flag value as address byte, one-byte zero length
		send_frame(FLAG_BYTE, 8'hFF, 0, 1'b0, 1'b1, 1'b1, -1);
		// two-byte zero length
		send_frame(8'h00, 8'hEF, 0, 1'b1, 1'b1, 1'b1, -1);
		// bad check byte, frame still accepted
		send_frame(8'hFC, 8'h10, 3, 1'b0, 1'b0, 1'b1, -1);
		// wrong end byte
		send_frame(8'h03, 8'h3F, 2, 1'b1, 1'b1, 1'b0, -1);
		set_max_payload(15'd2);
		// length and limit reached on the same byte
		send_frame(8'h55, 8'hAA, 2, 1'b0, 1'b1, 1'b1, -1);
		// largest length, cut off by the limit
		send_frame(8'hAA, 8'h55, 32767, 1'b1, 1'b1, 1'b1, -1);
		set_max_payload(15'h7FFF);
		send_frame(8'h0F, 8'hF0, 127, 1'b0, 1'b1, 1'b1, -1);

		for (int seg = 0; bytes_sent < ITEMS; seg++) begin
			case (seg % 4)
				0: begin
					send_idle = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle = 63;
					stall_pct = 0;
				end
				2: begin
					send_idle = 0;
					stall_pct = 63;
				end
				default: begin
					send_idle = 13;
					stall_pct = 13;
				end
			endcase
			case (seg % 6)
				0: set_max_payload(15'd1);
				1: set_max_payload(15'($urandom_range(2, 8)));
				2: set_max_payload(15'h7FFF);
				3: set_max_payload(15'($urandom_range(9, 64)));
				4: set_max_payload(15'($urandom_range(65, 32767)));
				default: set_max_payload(MAX_PAYLOAD_RST);
			endcase
			seg_end = bytes_sent + 160;
			while (bytes_sent < seg_end && bytes_sent < ITEMS) begin
				random_frame();
				// hold off mid-phase until the output side has caught up
				if (seg == 1 && !paused && bytes_sent > seg_end - 80) begin
					drain();
					paused = 1'b1;
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (outstanding != 0) begin
			$error("%0d expected results never arrived", outstanding);
		end
		if (fail_count == 0 && outstanding == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/cmdf_pkg.sv
hw/rtl/cmdf_front.sv
hw/rtl/cmdf_fifo.sv
hw/rtl/cmux_basic_frame_deframer.sv
hw/rtl/cmdf_checker.sv
verif/cmux_deframer_checker.sv
verif/tb_cmux_basic_frame_deframer.sv
